// ----- src/wis_pkg.sv -----
// Shared types and constants for the i32 stack executor.
`timescale 1ns / 1ps
package wis_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 7;

    // WebAssembly opcode bytes
    localparam logic [7:0] OP_END   = 8'h0B;
    localparam logic [7:0] OP_CONST = 8'h41;
    localparam logic [7:0] OP_EQZ   = 8'h45;
    localparam logic [7:0] OP_ADD   = 8'h6A;
    localparam logic [7:0] OP_SUB   = 8'h6B;
    localparam logic [7:0] OP_MUL   = 8'h6C;
    localparam logic [7:0] OP_DIVS  = 8'h6D;
    localparam logic [7:0] OP_DIVU  = 8'h6E;
    localparam logic [7:0] OP_REMS  = 8'h6F;
    localparam logic [7:0] OP_AND   = 8'h71;
    localparam logic [7:0] OP_OR    = 8'h72;
    localparam logic [7:0] OP_XOR   = 8'h73;
    localparam logic [7:0] OP_SHL   = 8'h74;
    localparam logic [7:0] OP_SHRS  = 8'h75;
    localparam logic [7:0] OP_SHRU  = 8'h76;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OVER    = 3'd1,
        ST_UNDER   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_DIVOVF  = 3'd4,
        ST_UNKNOWN = 3'd5,
        ST_HALTED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_CONST,
        CLS_EQZ,
        CLS_BIN,
        CLS_UNKNOWN
    } cls_t;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_SHL,
        ALU_SHRS,
        ALU_SHRU,
        ALU_DIVS,
        ALU_DIVU,
        ALU_REMS
    } alu_t;

    typedef struct packed {
        logic              start;
        cls_t              cls;
        alu_t              alu;
        logic [WORD_W-1:0] imm;
    } item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_EXEC,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

// ----- src/wasm_i32_stack_executor.sv -----
// Top level of the WebAssembly i32 stack executor.
//
//  channel  | handshake    | payload
//  ---------+--------------+--------------------------------------------
//  request  | push / full  | program_start, opcode, immediate
//  result   | empty / pop  | top_value, stack_depth, status
//
// In the back end a request passes IDLE and DONE for end, const, eqz and
// errors found at decode; IDLE, READ, EXEC and DONE for non-divide binary
// ops and divide errors; and also DIV for div/rem (32-step divider), plus
// any wait for pop on the result register. The top of stack is cached in
// a register; the rest sits in a RAM whose read is registered and is taken
// in READ for binary ops. A two-entry request queue lets the front accept
// while the back works or the result waits. Reset empties the stack and clears the halt; no clearing pass is needed.
`timescale 1ns / 1ps
module wasm_i32_stack_executor import wis_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               program_start,
    input  logic [7:0]         opcode,
    input  logic [WORD_W-1:0]  immediate,
    output logic               empty,
    input  logic               pop,
    output logic [WORD_W-1:0]  top_value,
    output logic [DEPTH_W-1:0] stack_depth,
    output logic [2:0]         status
);

    logic  q_valid;
    item_t q_item;
    logic  q_take;

    wis_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .program_start (program_start),
        .opcode        (opcode),
        .immediate     (immediate),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_take        (q_take)
    );

    wis_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .status      (status)
    );

endmodule

// ----- src/wis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/wis_front.sv -----
// Front end: accepts requests, classifies the opcode, queues for the back end.
`timescale 1ns / 1ps
module wis_front import wis_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              program_start,
    input  logic [7:0]        opcode,
    input  logic [WORD_W-1:0] immediate,
    output logic              q_valid,
    output item_t             q_item,
    input  logic              q_take
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      new_item;
    logic       wr_en;

    always_comb
    begin
        new_item.start = program_start;
        new_item.imm   = immediate;
        new_item.cls   = CLS_BIN;
        new_item.alu   = ALU_ADD;
        case (opcode)
            OP_END:   new_item.cls = CLS_END;
            OP_CONST: new_item.cls = CLS_CONST;
            OP_EQZ:   new_item.cls = CLS_EQZ;
            OP_ADD:   new_item.alu = ALU_ADD;
            OP_SUB:   new_item.alu = ALU_SUB;
            OP_MUL:   new_item.alu = ALU_MUL;
            OP_DIVS:  new_item.alu = ALU_DIVS;
            OP_DIVU:  new_item.alu = ALU_DIVU;
            OP_REMS:  new_item.alu = ALU_REMS;
            OP_AND:   new_item.alu = ALU_AND;
            OP_OR:    new_item.alu = ALU_OR;
            OP_XOR:   new_item.alu = ALU_XOR;
            OP_SHL:   new_item.alu = ALU_SHL;
            OP_SHRS:  new_item.alu = ALU_SHRS;
            OP_SHRU:  new_item.alu = ALU_SHRU;
            default:  new_item.cls = CLS_UNKNOWN;
        endcase
    end

    assign full    = (cnt_reg == 2'd2);
    assign wr_en   = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(q_take && q_valid);
        end
    end

endmodule

// ----- src/wis_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wis_div import wis_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;
    logic              fits;

    assign rem_sh    = {rem_reg, quo_reg[WORD_W-1]};
    assign diff      = rem_sh - {1'b0, dvs_reg};
    assign fits      = !diff[WORD_W];
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/wis_back.sv -----
// Back end: operand stack, ALU, divider control and result register.
`timescale 1ns / 1ps
module wis_back import wis_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_take,
    output logic               empty,
    input  logic               pop,
    output logic [WORD_W-1:0]  top_value,
    output logic [DEPTH_W-1:0] stack_depth,
    output logic [2:0]         status
);

    back_state_t       state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [WORD_W-1:0] tos_reg, tos_next;
    logic [WORD_W-1:0] nos_reg, nos_next;
    logic              halted_reg, halted_next;
    item_t             cur_reg, cur_next;
    status_t           st_reg, st_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_top_reg, out_top_next;
    logic [SP_W-1:0]   out_sp_reg, out_sp_next;
    status_t           out_st_reg, out_st_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              div_start;
    logic [WORD_W-1:0] div_a, div_b;
    logic              div_done;
    logic [WORD_W-1:0] div_quo, div_rem, div_sel;

    logic [SP_W-1:0]   sp_eff;
    logic              halt_eff;
    logic              out_free;
    logic [WORD_W-1:0] alu_res;
    logic [WORD_W-1:0] mag_a, mag_b;

    wis_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wis_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || pop;
    assign q_take   = (state_reg == B_IDLE) && q_valid;
    assign sp_eff   = q_item.start ? '0 : sp_reg;
    assign halt_eff = q_item.start ? 1'b0 : halted_reg;

    // bin ops: left = nos (second from top), right = tos
    always_comb
    begin
        case (cur_reg.alu)
            ALU_ADD:  alu_res = nos_reg + tos_reg;
            ALU_SUB:  alu_res = nos_reg - tos_reg;
            ALU_MUL:  alu_res = nos_reg * tos_reg;
            ALU_AND:  alu_res = nos_reg & tos_reg;
            ALU_OR:   alu_res = nos_reg | tos_reg;
            ALU_XOR:  alu_res = nos_reg ^ tos_reg;
            ALU_SHL:  alu_res = nos_reg << tos_reg[4:0];
            ALU_SHRU: alu_res = nos_reg >> tos_reg[4:0];
            ALU_SHRS: alu_res = WORD_W'($signed(nos_reg) >>> tos_reg[4:0]);
            default:  alu_res = '0;
        endcase
    end

    assign mag_a   = (cur_reg.alu != ALU_DIVU && nos_reg[WORD_W-1]) ? -nos_reg : nos_reg;
    assign mag_b   = (cur_reg.alu != ALU_DIVU && tos_reg[WORD_W-1]) ? -tos_reg : tos_reg;
    assign div_a   = mag_a;
    assign div_b   = mag_b;
    assign div_sel = (cur_reg.alu == ALU_REMS) ? div_rem : div_quo;

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        tos_next       = tos_reg;
        nos_next       = nos_reg;
        halted_next    = halted_reg;
        cur_next       = cur_reg;
        st_next        = st_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !pop;
        out_top_next   = out_top_reg;
        out_sp_next    = out_sp_reg;
        out_st_next    = out_st_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(sp_reg - 1'b1);
        ram_raddr      = ADDR_W'(sp_eff - SP_W'(2));
        div_start      = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next    = q_item;
                    sp_next     = sp_eff;
                    halted_next = halt_eff;
                    st_next     = ST_OK;
                    state_next  = B_DONE;
                    if (halt_eff)
                    begin
                        st_next = ST_HALTED;
                    end
                    else
                    begin
                        case (q_item.cls)
                            CLS_END: st_next = ST_OK;
                            CLS_CONST:
                            begin
                                if (sp_eff == SP_W'(STACK_DEPTH))
                                begin
                                    st_next     = ST_OVER;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    // spill the cached top before the push
                                    ram_we    = (sp_eff != '0);
                                    ram_waddr = ADDR_W'(sp_eff - 1'b1);
                                    tos_next  = q_item.imm;
                                    sp_next   = sp_eff + 1'b1;
                                end
                            end
                            CLS_EQZ:
                            begin
                                if (sp_eff == '0)
                                begin
                                    st_next     = ST_UNDER;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    tos_next = WORD_W'(tos_reg == '0);
                                end
                            end
                            CLS_BIN:
                            begin
                                if (sp_eff < SP_W'(2))
                                begin
                                    st_next     = ST_UNDER;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = B_READ;
                                end
                            end
                            default:
                            begin
                                st_next     = ST_UNKNOWN;
                                halted_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            B_READ:
            begin
                nos_next   = ram_rdata;
                state_next = B_EXEC;
            end
            B_EXEC:
            begin
                state_next = B_DONE;
                if (cur_reg.alu == ALU_DIVS || cur_reg.alu == ALU_DIVU
                    || cur_reg.alu == ALU_REMS)
                begin
                    if (tos_reg == '0)
                    begin
                        st_next     = ST_DIVZERO;
                        halted_next = 1'b1;
                    end
                    else if (cur_reg.alu == ALU_DIVS && nos_reg == {1'b1, {(WORD_W-1){1'b0}}}
                             && tos_reg == '1)
                    begin
                        st_next     = ST_DIVOVF;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = B_DIV;
                        case (cur_reg.alu)
                            ALU_DIVS: neg_next = nos_reg[WORD_W-1] ^ tos_reg[WORD_W-1];
                            ALU_REMS: neg_next = nos_reg[WORD_W-1];
                            default:  neg_next = 1'b0;
                        endcase
                    end
                end
                else
                begin
                    tos_next = alu_res;
                    sp_next  = sp_reg - 1'b1;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = neg_reg ? -div_sel : div_sel;
                    sp_next    = sp_reg - 1'b1;
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_top_next   = (sp_reg != '0) ? tos_reg : '0;
                    out_sp_next    = sp_reg;
                    out_st_next    = st_reg;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        tos_reg     <= tos_next;
        nos_reg     <= nos_next;
        cur_reg     <= cur_next;
        st_reg      <= st_next;
        neg_reg     <= neg_next;
        out_top_reg <= out_top_next;
        out_sp_reg  <= out_sp_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign top_value   = out_top_reg;
    assign stack_depth = DEPTH_W'(out_sp_reg);
    assign status      = out_st_reg;

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result loaded outside completion state");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DONE && out_free && st_reg != ST_OK && st_reg != ST_HALTED)
        |-> halted_reg)
        else $error("error reported without halt");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == B_DIV)
        else $error("divider finished outside divide wait");
`endif

endmodule
